### src/owsh_pkg.sv
// shared constants, atan table and register codes for the omni wheel speed block
`timescale 1ns / 1ps
`default_nettype none

package owsh_pkg;

  localparam int unsigned ZW      = 26;
  localparam int unsigned SXW     = 33;
  localparam int unsigned ATAN_W  = 23;
  localparam int unsigned ATAN_N  = 24;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned DEG_W   = 9;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned ROLL_W  = 17;
  localparam int unsigned SPD_W   = 32;
  localparam int unsigned OUT_W   = 17;

  localparam int          DEG_FULL      = 360;
  localparam int          DEG_HALF      = 180;
  localparam int          DEG_QUARTER   = 90;
  localparam int          ROLL_BAND     = 3;
  localparam int          GAIN_Q8       = 333;
  localparam int          ROLL_BASE_Q8  = 7680;
  localparam int          ROLL_LIMIT_Q8 = 38400;
  localparam int          BLEND_ONE     = 256;
  localparam int          DEG_HALF_Q16  = 11796480;
  localparam int          DEG_QTR_Q16   = 5898240;
  localparam int          CORDIC_GAIN   = 652032874;
  localparam int          SINE_ONE      = 1073741824;
  localparam int          OUT_MAX       = 65535;
  localparam int          OUT_MIN       = -65536;

  localparam logic [ATAN_W-1:0] ATAN_Q16 [ATAN_N] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
    23'd234379,  23'd117304,  23'd58666,  23'd29335,
    23'd14668,   23'd7334,    23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,
    23'd57,      23'd29,      23'd14,     23'd7,
    23'd4,       23'd2,       23'd1,      23'd0
  };

  typedef enum logic [IDX_W-1:0] {
    REG_WHEEL_ANGLE = 2'd0,
    REG_BLEND_RATE  = 2'd1
  } reg_idx_e;

endpackage

`default_nettype wire

### src/omni_wheel_speed_with_heading_hold.sv
// omni wheel speed command with heading hold, fully pipelined
`timescale 1ns / 1ps
`default_nettype none

// Takes one transfer per clock and returns one wheel speed per transfer, in order. The pipeline
// holds one stage per root bit of the square root, one per quotient bit of the divider by
// travel_time and one per step of each of the two CORDIC pipelines (atan2, then sine). A
// stalled output holds the whole pipeline; input is taken whenever the output register is
// empty or being read. Configuration writes are always ready; make them while no item is in
// flight, since items already inside the pipeline read the registers late.
module omni_wheel_speed_with_heading_hold #(
  parameter int unsigned COORD_BITS   = 15,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic [owsh_pkg::IDX_W-1:0]           cfg_index_i,
  input  wire logic [owsh_pkg::DEG_W-1:0]           cfg_data_i,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_ready_o,
  input  wire logic [owsh_pkg::DEG_W-1:0]           heading_deg_i,
  input  wire logic [owsh_pkg::TIME_W-1:0]          travel_time_i,
  input  wire logic signed [COORD_BITS-1:0]         goal_x_i,
  input  wire logic signed [COORD_BITS-1:0]         pos_x_i,
  input  wire logic signed [COORD_BITS-1:0]         pos_y_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_ready_i,
  output      logic signed [owsh_pkg::OUT_W-1:0]    wheel_speed_o
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned N      = CORDIC_STEPS;
  localparam int unsigned RW     = CB + 1;
  localparam int unsigned SQW    = 2 * CB;
  localparam int unsigned XW     = CB + 19;
  localparam int unsigned ZW     = owsh_pkg::ZW;
  localparam int unsigned SXW    = owsh_pkg::SXW;
  localparam int unsigned NS     = 10 + 2 * RW + 2 * N;
  localparam int unsigned V_ROLL = 1;
  localparam int unsigned V_MOD  = 5 + 2 * RW + N;
  localparam int unsigned V_FOLD = 6 + 2 * RW + N;

  typedef struct packed {
    logic signed [CB:0]   dx;
    logic signed [CB-1:0] py;
    logic [15:0]          t;
    logic signed [9:0]    hw;
  } in_t;

  typedef struct packed {
    logic signed [CB:0]   dx;
    logic signed [CB-1:0] py;
    logic [15:0]          t;
    logic signed [16:0]   roll;
  } base_t;

  typedef struct packed {
    base_t          b;
    logic [SQW-1:0] sqx;
    logic [SQW-1:0] sqy;
  } sqr_t;

  typedef struct packed {
    base_t           b;
    logic [2*RW-1:0] rad;
    logic [RW+2:0]   rem;
    logic [RW-1:0]   root;
  } rt_t;

  typedef struct packed {
    base_t         b;
    logic [RW-1:0] num;
    logic [15:0]   rem;
  } dv_t;

  typedef struct packed {
    logic [31:0]          speed;
    logic signed [16:0]   roll;
    logic                 sp;
    logic signed [9:0]    sdir;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } at_t;

  typedef struct packed {
    logic [31:0]        speed;
    logic signed [16:0] roll;
    logic signed [10:0] ang;
  } an_t;

  typedef struct packed {
    logic [31:0]           speed;
    logic signed [16:0]    roll;
    logic                  sp;
    logic signed [SXW-1:0] sval;
    logic signed [SXW-1:0] x;
    logic signed [SXW-1:0] y;
    logic signed [ZW-1:0]  z;
  } sn_t;

  typedef struct packed {
    logic               neg;
    logic [62:0]        prod;
    logic signed [16:0] roll;
  } ml_t;

  typedef struct packed {
    logic signed [43:0] tr;
    logic signed [26:0] rr;
  } bl_t;

  logic [owsh_pkg::DEG_W-1:0] wheel_angle_q;
  logic [owsh_pkg::DEG_W-1:0] blend_rate_q;
  logic [NS-1:0]              vld_q;
  logic                       adv;

  in_t  in_q,  in_d;
  sqr_t sqr_q, sqr_d;
  rt_t  rt_q  [RW+1];
  dv_t  dv_q  [RW];
  dv_t  dv0;
  at_t  at_q  [N+1];
  an_t  dir_q, dir_d;
  an_t  mod_q, mod_d;
  sn_t  sn_q  [N+1];
  ml_t  ml_q,  ml_d;
  bl_t  bl_q,  bl_d;
  logic signed [owsh_pkg::OUT_W-1:0] out_q, out_d;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_angle_q <= '0;
      blend_rate_q  <= owsh_pkg::DEG_W'(owsh_pkg::BLEND_ONE);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        owsh_pkg::REG_WHEEL_ANGLE: wheel_angle_q <= cfg_data_i;
        owsh_pkg::REG_BLEND_RATE:  blend_rate_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  assign adv         = !vld_q[NS-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // input stage: delta x and wrapped heading
  always_comb begin
    logic [8:0] hm;
    hm = heading_deg_i;
    if (heading_deg_i >= 9'(owsh_pkg::DEG_FULL)) begin
      hm = heading_deg_i - 9'(owsh_pkg::DEG_FULL);
    end
    in_d.hw = $signed({1'b0, hm});
    if (hm > 9'(owsh_pkg::DEG_HALF)) begin
      in_d.hw = $signed({1'b0, hm}) - 10'sd360;
    end
    in_d.dx = $signed({goal_x_i[CB-1], goal_x_i}) - $signed({pos_x_i[CB-1], pos_x_i});
    in_d.py = pos_y_i;
    in_d.t  = travel_time_i;
  end

  // squares and rotation correction
  always_comb begin
    logic signed [19:0]    hp;
    logic signed [19:0]    rl;
    logic signed [SQW+1:0] dsq;
    logic signed [SQW-1:0] psq;
    hp  = 20'(in_q.hw) * 20'sd333;
    rl  = '0;
    if (in_q.hw >= 10'sd3) begin
      rl = -20'sd7680 - hp;
      if (rl < -20'sd38400) begin
        rl = -20'sd38400;
      end
    end else if (in_q.hw <= -10'sd3) begin
      rl = 20'sd7680 - hp;
      if (rl > 20'sd38400) begin
        rl = 20'sd38400;
      end
    end
    dsq = (SQW+2)'(in_q.dx) * (SQW+2)'(in_q.dx);
    psq = SQW'(in_q.py) * SQW'(in_q.py);
    sqr_d.b.dx   = in_q.dx;
    sqr_d.b.py   = in_q.py;
    sqr_d.b.t    = in_q.t;
    sqr_d.b.roll = rl[16:0];
    sqr_d.sqx    = dsq[SQW-1:0];
    sqr_d.sqy    = psq[SQW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q     <= in_d;
      sqr_q    <= sqr_d;
      rt_q[0].b    <= sqr_q.b;
      rt_q[0].rad  <= {1'b0, ({1'b0, sqr_q.sqx} + {1'b0, sqr_q.sqy})};
      rt_q[0].rem  <= '0;
      rt_q[0].root <= '0;
    end
  end

  // square root, one root bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    rt_t          nx;
    logic [RW+2:0] remsh;
    logic [RW+2:0] trial;
    logic          ge;
    always_comb begin
      remsh   = {rt_q[k].rem[RW:0], rt_q[k].rad[2*RW-1 -: 2]};
      trial   = {1'b0, rt_q[k].root, 2'b01};
      ge      = remsh >= trial;
      nx.b    = rt_q[k].b;
      nx.rad  = {rt_q[k].rad[2*RW-3:0], 2'b00};
      nx.rem  = ge ? remsh - trial : remsh;
      nx.root = {rt_q[k].root[RW-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_q[k+1] <= nx;
      end
    end
  end

  assign dv0.b   = rt_q[RW].b;
  assign dv0.num = rt_q[RW].root;
  assign dv0.rem = '0;

  // distance over time, one quotient bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_div
    dv_t         src;
    dv_t         nx;
    logic [16:0] rsh;
    logic [16:0] diff;
    logic        ge;
    if (k == 0) begin : g_first
      assign src = dv0;
    end else begin : g_rest
      assign src = dv_q[k-1];
    end
    always_comb begin
      rsh    = {src.rem, src.num[RW-1]};
      diff   = rsh - {1'b0, src.b.t};
      ge     = rsh >= {1'b0, src.b.t};
      nx.b   = src.b;
      nx.rem = ge ? diff[15:0] : rsh[15:0];
      nx.num = {src.num[RW-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k] <= nx;
      end
    end
  end

  // atan2 setup: axis cases and left half-plane flip
  always_ff @(posedge clk_i) begin
    logic signed [XW-1:0] pye;
    logic signed [XW-1:0] dxe;
    if (adv) begin
      pye = XW'(dv_q[RW-1].b.py);
      dxe = XW'(dv_q[RW-1].b.dx);
      at_q[0].speed <= (dv_q[RW-1].b.t == '0) ? '1 : 32'(dv_q[RW-1].num);
      at_q[0].roll  <= dv_q[RW-1].b.roll;
      at_q[0].sp    <= (dv_q[RW-1].b.dx == '0) || (dv_q[RW-1].b.py == '0);
      if (dv_q[RW-1].b.dx == '0) begin
        at_q[0].sdir <= dv_q[RW-1].b.py[CB-1] ? 10'sd180 : 10'sd0;
      end else begin
        at_q[0].sdir <= dv_q[RW-1].b.dx[CB] ? -10'sd90 : 10'sd90;
      end
      if (dv_q[RW-1].b.py[CB-1]) begin
        at_q[0].x <= (-pye) <<< 16;
        at_q[0].y <= (-dxe) <<< 16;
        at_q[0].z <= (dv_q[RW-1].b.dx > 0) ? ZW'(owsh_pkg::DEG_HALF_Q16)
                                           : -ZW'(owsh_pkg::DEG_HALF_Q16);
      end else begin
        at_q[0].x <= pye <<< 16;
        at_q[0].y <= dxe <<< 16;
        at_q[0].z <= '0;
      end
    end
  end

  // atan2 vectoring
  for (genvar i = 0; i < N; i++) begin : g_atan
    at_t                  nx;
    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic signed [ZW-1:0] ae;
    always_comb begin
      sx = at_q[i].x >>> i;
      sy = at_q[i].y >>> i;
      ae = $signed({{(ZW-owsh_pkg::ATAN_W){1'b0}}, owsh_pkg::ATAN_Q16[i]});
      nx = at_q[i];
      if (!at_q[i].y[XW-1]) begin
        nx.x = at_q[i].x + sy;
        nx.y = at_q[i].y - sx;
        nx.z = at_q[i].z + ae;
      end else begin
        nx.x = at_q[i].x - sy;
        nx.y = at_q[i].y + sx;
        nx.z = at_q[i].z - ae;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        at_q[i+1] <= nx;
      end
    end
  end

  // direction in whole degrees minus wheel angle
  always_comb begin
    logic signed [ZW-1:0] zt;
    logic signed [ZW-1:0] dc;
    logic signed [9:0]    dir;
    zt = at_q[N].z + (at_q[N].z[ZW-1] ? ZW'(65535) : ZW'(0));
    dc = zt >>> 16;
    dir = at_q[N].sp ? at_q[N].sdir : dc[9:0];
    dir_d.speed = at_q[N].speed;
    dir_d.roll  = at_q[N].roll;
    dir_d.ang   = 11'(dir) - $signed({2'b00, wheel_angle_q});
  end

  // reduce to -179..180
  always_comb begin
    logic signed [10:0] a;
    a = dir_q.ang;
    if (a < -11'sd720) begin
      a = a + 11'sd1080;
    end else if (a < -11'sd360) begin
      a = a + 11'sd720;
    end else if (a < 11'sd0) begin
      a = a + 11'sd360;
    end
    if (a > 11'sd180) begin
      a = a - 11'sd360;
    end
    mod_d.speed = dir_q.speed;
    mod_d.roll  = dir_q.roll;
    mod_d.ang   = a;
  end

  always_ff @(posedge clk_i) begin
    logic signed [10:0] a;
    if (adv) begin
      dir_q <= dir_d;
      mod_q <= mod_d;
      a = mod_q.ang;
      if (mod_q.ang > 11'sd90) begin
        a = 11'sd180 - mod_q.ang;
      end else if (mod_q.ang < -11'sd90) begin
        a = -11'sd180 - mod_q.ang;
      end
      sn_q[0].speed <= mod_q.speed;
      sn_q[0].roll  <= mod_q.roll;
      sn_q[0].sp    <= (a == 11'sd0) || (a == 11'sd90) || (a == -11'sd90);
      if (a == 11'sd0) begin
        sn_q[0].sval <= '0;
      end else if (a > 11'sd0) begin
        sn_q[0].sval <= SXW'(owsh_pkg::SINE_ONE);
      end else begin
        sn_q[0].sval <= -SXW'(owsh_pkg::SINE_ONE);
      end
      sn_q[0].x <= SXW'(owsh_pkg::CORDIC_GAIN);
      sn_q[0].y <= '0;
      sn_q[0].z <= ZW'(a) <<< 16;
    end
  end

  // sine rotation
  for (genvar i = 0; i < N; i++) begin : g_sine
    sn_t                   nx;
    logic signed [SXW-1:0] sx;
    logic signed [SXW-1:0] sy;
    logic signed [ZW-1:0]  ae;
    always_comb begin
      sx = sn_q[i].x >>> i;
      sy = sn_q[i].y >>> i;
      ae = $signed({{(ZW-owsh_pkg::ATAN_W){1'b0}}, owsh_pkg::ATAN_Q16[i]});
      nx = sn_q[i];
      if (!sn_q[i].z[ZW-1]) begin
        nx.x = sn_q[i].x - sy;
        nx.y = sn_q[i].y + sx;
        nx.z = sn_q[i].z - ae;
      end else begin
        nx.x = sn_q[i].x + sy;
        nx.y = sn_q[i].y - sx;
        nx.z = sn_q[i].z + ae;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sn_q[i+1] <= nx;
      end
    end
  end

  // speed times sine magnitude
  always_comb begin
    logic signed [SXW-1:0] s;
    logic signed [SXW-1:0] ab;
    s  = sn_q[N].sp ? sn_q[N].sval : sn_q[N].y;
    ab = s[SXW-1] ? -s : s;
    ml_d.neg  = s[SXW-1];
    ml_d.roll = sn_q[N].roll;
    ml_d.prod = {31'b0, sn_q[N].speed} * {32'b0, ab[30:0]};
  end

  // blend weights
  always_comb begin
    logic [32:0]        mag;
    logic signed [33:0] term;
    logic [8:0]         r;
    logic [9:0]         wr;
    mag  = ml_q.prod[62:30];
    term = ml_q.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    r    = (blend_rate_q > 9'(owsh_pkg::BLEND_ONE)) ? 9'(owsh_pkg::BLEND_ONE) : blend_rate_q;
    wr   = 10'(owsh_pkg::BLEND_ONE) - {1'b0, r};
    bl_d.tr = 44'(term) * $signed({35'b0, r});
    bl_d.rr = 27'(ml_q.roll) * $signed({17'b0, wr});
  end

  // Q16 to integer, cut toward zero, saturate
  always_comb begin
    logic signed [52:0] total;
    logic signed [52:0] adj;
    logic signed [52:0] res;
    total = (53'(bl_q.tr) <<< 8) + 53'(bl_q.rr);
    adj   = total + (total[52] ? 53'sd65535 : 53'sd0);
    res   = adj >>> 16;
    if (res > 53'(owsh_pkg::OUT_MAX)) begin
      out_d = 17'(owsh_pkg::OUT_MAX);
    end else if (res < 53'(owsh_pkg::OUT_MIN)) begin
      out_d = 17'(owsh_pkg::OUT_MIN);
    end else begin
      out_d = res[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ml_q  <= ml_d;
      bl_q  <= bl_d;
      out_q <= out_d;
    end
  end

  assign wheel_speed_o = out_q;

  // rotation correction stays inside its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[V_ROLL] |-> (sqr_q.b.roll <= 17'sd38400) && (sqr_q.b.roll >= -17'sd38400))
    else $error("roll correction out of range");

  // reduced angle lies in -179..180
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[V_MOD] |-> (mod_q.ang <= 11'sd180) && (mod_q.ang > -11'sd180))
    else $error("angle reduction out of range");

  // folded sine angle lies within a quarter turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[V_FOLD] |-> (sn_q[0].z <= ZW'(owsh_pkg::DEG_QTR_Q16))
                   && (sn_q[0].z >= -ZW'(owsh_pkg::DEG_QTR_Q16)))
    else $error("sine angle fold out of range");

endmodule

`default_nettype wire
